### rtl/mm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_pkg - shared types and constants of the MurmurHash3 x86_32 core
// Mixing constants, datapath command codes and the status bundle.
// ----------------------------------------------------------------------------
package mm3_pkg;

  localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2 = 32'h1b873593;
  localparam logic [31:0] MIX_N  = 32'he6546b64;
  localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
  localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

  typedef logic [3:0] mm3_cmd_t;

  localparam mm3_cmd_t CMD_NOP    = 4'd0;
  localparam mm3_cmd_t CMD_ACCEPT = 4'd1;  // take an input beat
  localparam mm3_cmd_t CMD_LDTAIL = 4'd2;  // load leftover tail bytes
  localparam mm3_cmd_t CMD_KMUL1  = 4'd3;  // k *= c1
  localparam mm3_cmd_t CMD_KMUL2  = 4'd4;  // k = rotl15(k) * c2
  localparam mm3_cmd_t CMD_BMIX   = 4'd5;  // h = rotl13(h ^ k) * 5 + n
  localparam mm3_cmd_t CMD_FXOR_T = 4'd6;  // w = h ^ k ^ len
  localparam mm3_cmd_t CMD_FXOR_N = 4'd7;  // w = h ^ len
  localparam mm3_cmd_t CMD_FMUL1  = 4'd8;  // w = (w ^ w >> 16) * m1
  localparam mm3_cmd_t CMD_FMUL2  = 4'd9;  // w = (w ^ w >> 13) * m2
  localparam mm3_cmd_t CMD_FOUT   = 4'd10; // emit w ^ w >> 16, restart

  typedef struct packed {
    logic pos_full;  // three bytes pending, next byte completes a block
    logic tail_nz;   // tail bytes pending
    logic out_free;  // output register can take a result this cycle
  } mm3_status_t;

endpackage

### rtl/mm3_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_if - valid/ready channels of the MurmurHash3 core
// Key byte input, hash output and seed write channels.
// ----------------------------------------------------------------------------
interface mm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, key_byte, byte_valid, last, input ready);
  modport sink   (input valid, key_byte, byte_valid, last, output ready);
endinterface

interface mm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface mm3_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;

  modport source (output valid, seed, input ready);
  modport sink   (input valid, seed, output ready);
endinterface

### rtl/mm3_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_ctrl - sequencer of the MurmurHash3 core
// Steps the datapath through block mixing and finalisation.
// ----------------------------------------------------------------------------
module mm3_ctrl
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        in_ready,
  input  mm3_status_t status,
  output mm3_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BM1   = 4'd1;
  localparam logic [3:0] ST_BM2   = 4'd2;
  localparam logic [3:0] ST_BMIX  = 4'd3;
  localparam logic [3:0] ST_FINIT = 4'd4;
  localparam logic [3:0] ST_TM1   = 4'd5;
  localparam logic [3:0] ST_TM2   = 4'd6;
  localparam logic [3:0] ST_TXOR  = 4'd7;
  localparam logic [3:0] ST_FM1   = 4'd8;
  localparam logic [3:0] ST_FM2   = 4'd9;
  localparam logic [3:0] ST_FOUT  = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;  // finalise after the block in flight

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    cmd       = CMD_NOP;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd = CMD_ACCEPT;
          if (in_byte_valid && status.pos_full) begin
            fin_nxt   = in_last;
            state_nxt = ST_BM1;
          end else if (in_last) begin
            state_nxt = ST_FINIT;
          end
        end
      end
      ST_BM1: begin
        cmd       = CMD_KMUL1;
        state_nxt = ST_BM2;
      end
      ST_BM2: begin
        cmd       = CMD_KMUL2;
        state_nxt = ST_BMIX;
      end
      ST_BMIX: begin
        cmd       = CMD_BMIX;
        state_nxt = fin_r ? ST_FINIT : ST_IDLE;
        fin_nxt   = 1'b0;
      end
      ST_FINIT: begin
        if (status.tail_nz) begin
          cmd       = CMD_LDTAIL;
          state_nxt = ST_TM1;
        end else begin
          cmd       = CMD_FXOR_N;
          state_nxt = ST_FM1;
        end
      end
      ST_TM1: begin
        cmd       = CMD_KMUL1;
        state_nxt = ST_TM2;
      end
      ST_TM2: begin
        cmd       = CMD_KMUL2;
        state_nxt = ST_TXOR;
      end
      ST_TXOR: begin
        cmd       = CMD_FXOR_T;
        state_nxt = ST_FM1;
      end
      ST_FM1: begin
        cmd       = CMD_FMUL1;
        state_nxt = ST_FM2;
      end
      ST_FM2: begin
        cmd       = CMD_FMUL2;
        state_nxt = ST_FOUT;
      end
      ST_FOUT: begin
        if (status.out_free) begin
          cmd       = CMD_FOUT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        fin_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

### rtl/mm3_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm3_dp - datapath of the MurmurHash3 core
// Byte packing, key length, running hash and one shared multiplier.
// ----------------------------------------------------------------------------
module mm3_dp
  import mm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  mm3_cmd_t    cmd,
  output mm3_status_t status,
  input  logic [7:0]  in_key_byte,
  input  logic        in_byte_valid,
  input  logic        cfg_we,
  input  logic [31:0] cfg_seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);

  logic [31:0] seed_r, seed_nxt;
  logic [31:0] h_r, h_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] w_r, w_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] mix_t, mix_r;

  // shared multiplier, low 32 bits of the product
  always_comb begin
    mul_a = w_r;
    mul_b = MIX_C1;
    case (cmd)
      CMD_KMUL2: begin
        mul_a = {w_r[16:0], w_r[31:17]};
        mul_b = MIX_C2;
      end
      CMD_FMUL1: begin
        mul_a = w_r ^ {16'h0, w_r[31:16]};
        mul_b = FIN_M1;
      end
      CMD_FMUL2: begin
        mul_a = w_r ^ {13'h0, w_r[31:13]};
        mul_b = FIN_M2;
      end
      default: begin
        mul_a = w_r;
        mul_b = MIX_C1;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign mix_t = h_r ^ w_r;
  assign mix_r = {mix_t[18:0], mix_t[31:19]};

  always_comb begin
    seed_nxt      = seed_r;
    h_nxt         = h_r;
    pend_nxt      = pend_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    w_nxt         = w_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd)
      CMD_ACCEPT: begin
        if (in_byte_valid) begin
          len_nxt = len_r + 32'd1;
          case (pos_r)
            2'd0: pend_nxt[7:0]   = in_key_byte;
            2'd1: pend_nxt[15:8]  = in_key_byte;
            2'd2: pend_nxt[23:16] = in_key_byte;
            default: begin
              w_nxt    = {in_key_byte, pend_r};
              pend_nxt = 24'h0;
            end
          endcase
          pos_nxt = pos_r + 2'd1;
        end
      end
      CMD_LDTAIL: w_nxt = {8'h0, pend_r};
      CMD_KMUL1,
      CMD_KMUL2,
      CMD_FMUL1,
      CMD_FMUL2:  w_nxt = mul_p;
      CMD_BMIX:   h_nxt = {mix_r[29:0], 2'b00} + mix_r + MIX_N;
      CMD_FXOR_T: w_nxt = h_r ^ w_r ^ len_r;
      CMD_FXOR_N: w_nxt = h_r ^ len_r;
      CMD_FOUT: begin
        out_hash_nxt  = w_r ^ {16'h0, w_r[31:16]};
        out_valid_nxt = 1'b1;
        h_nxt         = seed_r;
        pend_nxt      = 24'h0;
        pos_nxt       = 2'd0;
        len_nxt       = 32'd0;
      end
      default: ;
    endcase
    // a seed write always updates seed_r; it reloads the running hash only before the key's first byte
    if (cfg_we) begin
      seed_nxt = cfg_seed;
      if (len_r == 32'd0 && pos_r == 2'd0) begin
        h_nxt = cfg_seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= 32'h0;
      h_r         <= 32'h0;
      pend_r      <= 24'h0;
      pos_r       <= 2'd0;
      len_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      h_r         <= h_nxt;
      pend_r      <= pend_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign status.pos_full = (pos_r == 2'd3);
  assign status.tail_nz  = (pos_r != 2'd0);
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

### rtl/murmur3_hash_32_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_hash_32_core - streaming MurmurHash3 x86_32 hasher
// Byte-wide key input, 32-bit hash output, writable seed.
// ----------------------------------------------------------------------------
// The core hashes a key fed one byte per beat and returns its 32-bit
// MurmurHash3 (x86_32 variant). A beat with byte_valid low carries no byte;
// a beat with last high ends the key, so a lone last beat gives the hash of
// the empty key. A byte that does not complete a 4-byte block is only stored;
// the fourth byte of a block is accepted, then put through two scramble
// multiplies and the body mix. Ending a key adds the length fold, two
// avalanche multiplies and the output load, and with tail bytes first the
// tail scramble, plus any wait for the output register to free.
// All multiplies go through one shared 32x32 unit, so these steps run in turn.
// The hash sits in an output register, so the next key's bytes are taken
// while it waits. The seed is taken over the cfg channel in the idle state;
// it loads the running hash at once if no byte of the key has arrived,
// otherwise it applies from the next key.
// ----------------------------------------------------------------------------
module murmur3_hash_32_core
  import mm3_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mm3_in_if.sink    in_chan,
  mm3_out_if.source out_chan,
  mm3_cfg_if.sink   cfg_chan
);

  mm3_cmd_t    cmd;
  mm3_status_t status;

  // seed beats taken only while the controller waits for a key beat,
  // so none lands on a block mix or a finalisation in progress
  assign cfg_chan.ready = in_chan.ready;

  mm3_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_byte_valid (in_chan.byte_valid),
    .in_last       (in_chan.last),
    .in_ready      (in_chan.ready),
    .status        (status),
    .cmd           (cmd)
  );

  mm3_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_key_byte    (in_chan.key_byte),
    .in_byte_valid  (in_chan.byte_valid),
    .cfg_we         (cfg_chan.valid && cfg_chan.ready),
    .cfg_seed       (cfg_chan.seed),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_hash_value (out_chan.hash_value)
  );

endmodule

### test/hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_checker - scoreboard for the MurmurHash3 x86_32 core
// Watches the seed, key byte and hash channels, predicts each key's hash and
// compares it with what the core returns, in order.
// ----------------------------------------------------------------------------
module hash_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_key_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_hash_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_seed,
  output int unsigned mismatches,
  output int unsigned hashes_due,
  output int unsigned hashes_checked
);

  localparam logic [31:0] BLK_MUL1   = 32'hcc9e2d51;
  localparam logic [31:0] BLK_MUL2   = 32'h1b873593;
  localparam logic [31:0] BODY_ADD   = 32'he6546b64;
  localparam logic [31:0] AVAL_MUL1  = 32'h85ebca6b;
  localparam logic [31:0] AVAL_MUL2  = 32'hc2b2ae35;
  localparam int unsigned REPORT_MAX = 10;

  logic [31:0] seed_reg;
  logic [31:0] acc_hash;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_fill;
  logic [31:0] byte_total;
  logic [31:0] expected_hashes[$];
  int unsigned bad_count;
  int unsigned seen_count;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * BLK_MUL1;
    t = rol32(t, 15);
    return t * BLK_MUL2;
  endfunction

  function automatic logic [31:0] final_mix(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * AVAL_MUL1;
    t = t ^ (t >> 13);
    t = t * AVAL_MUL2;
    return t ^ (t >> 16);
  endfunction

  always @(posedge clk) begin
    logic [31:0] h;
    logic [31:0] want;
    logic [31:0] due;
    if (!rst_n) begin
      seed_reg   = '0;
      acc_hash   = '0;
      tail_bytes = '0;
      tail_fill  = '0;
      byte_total = '0;
      expected_hashes.delete();
      bad_count  = 0;
      seen_count = 0;
    end else begin
      // seed reloads the running hash only before the key's first byte
      if (cfg_valid && cfg_ready) begin
        seed_reg = cfg_seed;
        if (byte_total == 0 && tail_fill == 0) begin
          acc_hash = cfg_seed;
        end
      end

      if (in_valid && in_ready) begin
        if (in_byte_valid) begin
          if (tail_fill == 2'd3) begin
            acc_hash = rol32(acc_hash ^ scramble_block({in_key_byte, tail_bytes}), 13)
                       * 32'd5 + BODY_ADD;
            tail_bytes = '0;
            tail_fill  = '0;
          end else begin
            tail_bytes = tail_bytes | (24'(in_key_byte) << (8 * tail_fill));
            tail_fill  = tail_fill + 2'd1;
          end
          byte_total = byte_total + 32'd1;
        end
        if (in_last) begin
          h = acc_hash;
          if (tail_fill != 0) begin
            h = h ^ scramble_block({8'h00, tail_bytes});
          end
          due = final_mix(h ^ byte_total);
          expected_hashes = {expected_hashes, due};
          acc_hash   = seed_reg;
          tail_bytes = '0;
          tail_fill  = '0;
          byte_total = '0;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_MAX) begin
            $display("%0t: unexpected hash beat %08h, none outstanding", $time,
                     out_hash_value);
          end
        end else begin
          want = expected_hashes.pop_front();
          seen_count++;
          if (out_hash_value !== want) begin
            bad_count++;
            if (bad_count <= REPORT_MAX) begin
              $display("%0t: hash %0d wrong: expected %08h, got %08h", $time,
                       seen_count, want, out_hash_value);
            end
          end
        end
      end
    end
    mismatches     <= bad_count;
    hashes_due     <= expected_hashes.size();
    hashes_checked <= seen_count;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - top of the MurmurHash3 x86_32 core test
// Drives seed writes and key byte streams with random gaps, stalls the hash
// output at random, and leaves prediction and comparison to hash_checker.
// ----------------------------------------------------------------------------
module testbench;

  // Beats that carry a byte or an end mark; pure filler beats are not counted
  localparam int unsigned TOTAL_BEATS = 750;
  // Length of the one forced output hold-off, in cycles
  localparam int unsigned LONG_HOLD   = 400;
  // Worst in-core work after the last beat is a block mix and a key close;
  // leave a margin on top
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned DRAIN_BOUND = 20000;
  localparam int unsigned PRESS_KEYS  = 20;

  logic clk;
  logic rst_n;

  mm3_in_if  in_bus ();
  mm3_out_if out_bus ();
  mm3_cfg_if cfg_bus ();

  int unsigned mismatches;
  int unsigned hashes_due;
  int unsigned hashes_checked;

  int unsigned beats_sent;
  int unsigned byte_count;
  int unsigned key_count;
  int unsigned seed_writes;
  bit          no_gaps;

  // hold-off request from the stimulus, served by the receiver process
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned stall_left;
  int unsigned run_left;

  murmur3_hash_32_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  hash_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_bus.valid),
    .in_ready       (in_bus.ready),
    .in_key_byte    (in_bus.key_byte),
    .in_byte_valid  (in_bus.byte_valid),
    .in_last        (in_bus.last),
    .out_valid      (out_bus.valid),
    .out_ready      (out_bus.ready),
    .out_hash_value (out_bus.hash_value),
    .cfg_valid      (cfg_bus.valid),
    .cfg_ready      (cfg_bus.ready),
    .cfg_seed       (cfg_bus.seed),
    .mismatches     (mismatches),
    .hashes_due     (hashes_due),
    .hashes_checked (hashes_checked)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Idle lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Key lengths: mostly short, covering every tail length and block crossings
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    else if (r < 70) return $urandom_range(1, 8);
    else if (r < 95) return $urandom_range(9, 24);
    else return $urandom_range(25, 64);
  endfunction

  // Seeds: the two extremes often, otherwise any value
  function automatic logic [31:0] pick_seed();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 32'h0000_0000;
    else if (r == 1) return 32'hffff_ffff;
    else return $urandom();
  endfunction

  // Offer one beat and hold it until accepted; then maybe go idle a while.
  // valid stays high on a zero gap so back-to-back beats need no re-raise.
  task automatic send_beat(input logic [7:0] b, input logic bv, input logic lst);
    int unsigned gap;
    in_bus.valid      <= 1'b1;
    in_bus.key_byte   <= b;
    in_bus.byte_valid <= bv;
    in_bus.last       <= lst;
    do @(posedge clk); while (!in_bus.ready);
    if (bv || lst) beats_sent++;
    if (bv) byte_count++;
    if (lst) key_count++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A whole key of random bytes, with the odd filler beat mixed in. The end
  // mark rides either on the final byte or on a separate empty beat.
  task automatic send_key(input int unsigned len, input bit separate_end);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1, !separate_end && (i == len - 1));
    end
    if (separate_end || len == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  // Stop offering, let every outstanding hash come back, then give the core
  // time to finish any block mix still running on a byte with no end mark.
  // The first edge lets the checker's count catch up with the last beat.
  task automatic settle_idle();
    int unsigned waited;
    waited = 0;
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (hashes_due != 0 && waited < DRAIN_BOUND) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.seed  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    seed_writes++;
  endtask

  // Hash receiver: random stalls and stretches of ready, plus the long
  // hold-off on request, counted down here cycle by cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
      run_left   = 0;
    end else if (hold_requests != hold_served) begin
      hold_served   = hold_requests;
      stall_left    = LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if (run_left != 0) begin
      run_left--;
      out_bus.ready <= 1'b1;
    end else begin
      stall_left    = pick_gap();
      run_left      = $urandom_range(1, 24);
      out_bus.ready <= (stall_left == 0);
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.key_byte    = 8'h00;
    in_bus.byte_valid  = 1'b0;
    in_bus.last        = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.seed       = 32'h0;
    beats_sent         = 0;
    byte_count         = 0;
    key_count          = 0;
    seed_writes        = 0;
    no_gaps            = 1'b0;
    hold_requests      = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part, seed still at its reset value of zero ---
    // empty key: a lone end mark, with junk on the byte lane
    send_beat(8'h55, 1'b0, 1'b1);
    // one byte, end mark on the same beat
    send_beat(8'hff, 1'b1, 1'b1);
    // three-byte tail closed by an empty end beat
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    send_beat(8'h7f, 1'b1, 1'b0);
    send_beat(8'haa, 1'b0, 1'b1);
    // exactly one block, no tail
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    // filler beat inside a key must not disturb it; five bytes, one in tail
    send_beat(8'h01, 1'b1, 1'b0);
    send_beat(8'haa, 1'b0, 1'b0);
    send_beat(8'h02, 1'b1, 1'b0);
    send_beat(8'h03, 1'b1, 1'b0);
    send_beat(8'h04, 1'b1, 1'b0);
    send_beat(8'hfe, 1'b1, 1'b1);

    // all-ones seed, loaded straight into the idle core
    settle_idle();
    write_seed(32'hffff_ffff);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h5a, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b1, 1'b1);

    // seed written part way through a key: this key keeps the old seed,
    // the next one picks up the new
    send_beat(8'h12, 1'b1, 1'b0);
    send_beat(8'h34, 1'b1, 1'b0);
    settle_idle();
    write_seed(32'h9747_b28c);
    send_beat(8'h56, 1'b1, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);

    // --- back-pressure: hold the output off while short keys keep coming,
    // so the output register fills and the core stops taking bytes ---
    settle_idle();
    hold_requests <= hold_requests + 1;
    no_gaps = 1'b1;
    repeat (PRESS_KEYS) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    no_gaps = 1'b0;

    // --- random phases: new seed, then a batch of keys ---
    while (beats_sent < TOTAL_BEATS) begin
      settle_idle();
      write_seed(pick_seed());
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        // reseed once some bytes of a key are already in
        repeat ($urandom_range(1, 7)) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        settle_idle();
        write_seed(pick_seed());
        send_key($urandom_range(0, 6), 1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(2, 10)) send_key(pick_len(), 1'($urandom_range(0, 1)));
    end
    no_gaps = 1'b0;

    settle_idle();
    $display("Covered %0d keys (%0d key bytes) over %0d seed writes,",
             key_count, byte_count, seed_writes);
    $display("with one %0d-cycle output hold-off.", LONG_HOLD);
    $display("Hashes compared: %0d; left outstanding: %0d; wrong or unexpected: %0d.",
             hashes_checked, hashes_due, mismatches);
    if (mismatches == 0 && hashes_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #6ms;
    $display("Run timed out");
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
rtl/mm3_pkg.sv
rtl/mm3_if.sv
rtl/mm3_ctrl.sv
rtl/mm3_dp.sv
rtl/murmur3_hash_32_core.sv
test/hash_checker.sv
test/testbench.sv
